@@ src/mmr_pkg.sv @@
`default_nettype none

package mmr_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int AXIS_W  = 16;
    localparam int REQ_W   = 8;
    localparam int WHEEL_W = 8;
    localparam int LIM_W   = 7;
    localparam int MASK_W  = 4;
    localparam int NUM_WHEELS = 4;

    // Internal widths: mix is +/-3000, its magnitude 12 bits, product below 2^19
    localparam int MIX_W  = 13;
    localparam int MAG_W  = 12;
    localparam int PROD_W = MAG_W + LIM_W;
    localparam int QUO_W  = LIM_W;
    localparam int DIFF_W = WHEEL_W + 1;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    // Fixed limits
    localparam int AXIS_LIMIT  = 1000;
    localparam int WHEEL_LIMIT = 100;
    localparam int MIN_LIMIT   = 10;
    localparam int RAMP_STEP   = 5;

    // Register map
    localparam int REG_MAX_SPEED    = 0;
    localparam int REG_REVERSE_MASK = 1;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [LIM_W-1:0]  MAX_SPEED_RESET    = 7'd35;
    localparam logic [MASK_W-1:0] REVERSE_MASK_RESET = 4'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_DRIVE = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_STOP  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MIX,
        ST_NORM,
        ST_DIV,
        ST_TGT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 load_in;
        logic                 do_exec;
        logic                 do_mix;
        logic                 do_norm;
        logic                 div_step;
        logic [DIV_CNT_W-1:0] div_shift;
        logic                 do_tgt;
        logic                 load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic is_drive;
    } dp_status_t;

endpackage

`default_nettype wire

@@ src/mmr_in_if.sv @@
`default_nettype none

interface mmr_in_if
    import mmr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic [REQ_W-1:0]         requested_limit;

    modport source (
        output valid, command, axis_x, axis_y, axis_z, requested_limit,
        input  ready
    );

    modport sink (
        input  valid, command, axis_x, axis_y, axis_z, requested_limit,
        output ready
    );
endinterface

`default_nettype wire

@@ src/mmr_out_if.sv @@
`default_nettype none

interface mmr_out_if
    import mmr_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [WHEEL_W-1:0] wheel_one;
    logic signed [WHEEL_W-1:0] wheel_two;
    logic signed [WHEEL_W-1:0] wheel_three;
    logic signed [WHEEL_W-1:0] wheel_four;
    logic                      running;
    logic                      write_needed;

    modport source (
        output valid, wheel_one, wheel_two, wheel_three, wheel_four,
               running, write_needed,
        input  ready
    );

    modport sink (
        input  valid, wheel_one, wheel_two, wheel_three, wheel_four,
               running, write_needed,
        output ready
    );
endinterface

`default_nettype wire

@@ src/mmr_ctrl.sv @@
`default_nettype none

module mmr_ctrl
    import mmr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  dp_status_t      status,
    output dp_cmd_t         cmd
);

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    // State, division counter and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sequence one transaction through the datapath
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.div_shift = div_cnt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.do_exec = 1'b1;
                state_next  = status.is_drive ? ST_MIX : ST_DONE;
            end
            ST_MIX:
            begin
                cmd.do_mix = 1'b1;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                cmd.do_norm  = 1'b1;
                div_cnt_next = DIV_CNT_W'(QUO_W - 1);
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_TGT;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            ST_TGT:
            begin
                cmd.do_tgt = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = cmd.load_out | (out_valid_reg & ~out_ready);
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ src/mmr_datapath.sv @@
`default_nettype none

module mmr_datapath
    import mmr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  dp_cmd_t                       cmd,
    output dp_status_t                    status,
    input  wire logic [CMD_W-1:0]         command,
    input  wire logic signed [AXIS_W-1:0] axis_x,
    input  wire logic signed [AXIS_W-1:0] axis_y,
    input  wire logic signed [AXIS_W-1:0] axis_z,
    input  wire logic [REQ_W-1:0]         requested_limit,
    input  wire logic [LIM_W-1:0]         max_speed,
    input  wire logic [MASK_W-1:0]        reverse_mask,
    output logic signed [WHEEL_W-1:0]     wheel_one,
    output logic signed [WHEEL_W-1:0]     wheel_two,
    output logic signed [WHEEL_W-1:0]     wheel_three,
    output logic signed [WHEEL_W-1:0]     wheel_four,
    output logic                          running,
    output logic                          write_needed
);

    localparam logic signed [DIFF_W-1:0] STEP_POS = DIFF_W'(RAMP_STEP);
    localparam logic signed [DIFF_W-1:0] STEP_NEG = -DIFF_W'(RAMP_STEP);
    localparam logic [QUO_W-1:0]         QUO_CAP  = QUO_W'(WHEEL_LIMIT);
    localparam logic [MAG_W-1:0]         NORM_MIN = MAG_W'(AXIS_LIMIT);
    localparam logic [REQ_W-1:0]         REQ_MIN  = REQ_W'(MIN_LIMIT);

    function automatic logic signed [MIX_W-1:0] clamp_axis(input logic signed [AXIS_W-1:0] v);
        logic signed [AXIS_W-1:0] hi;
        hi = AXIS_W'(AXIS_LIMIT);
        if (v > hi)
            return MIX_W'(AXIS_LIMIT);
        else if (v < -hi)
            return -MIX_W'(AXIS_LIMIT);
        else
            return $signed(v[MIX_W-1:0]);
    endfunction

    // Item registers
    logic [CMD_W-1:0]         cmd_reg;
    logic signed [AXIS_W-1:0] ax_reg, ay_reg, az_reg;
    logic [REQ_W-1:0]         req_reg;

    // Mix and division registers
    logic signed [MIX_W-1:0]  mix_reg [NUM_WHEELS];
    logic [LIM_W-1:0]         lim_reg;
    logic [PROD_W-1:0]        rem_reg [NUM_WHEELS];
    logic [QUO_W-1:0]         quo_reg [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]    neg_reg;
    logic [MAG_W-1:0]         norm_reg;

    // Block state
    logic signed [WHEEL_W-1:0] target_reg  [NUM_WHEELS];
    logic signed [WHEEL_W-1:0] applied_reg [NUM_WHEELS];
    logic                      motors_reg;
    logic                      write_reg;

    // Output register
    logic signed [WHEEL_W-1:0] wheel_out_reg [NUM_WHEELS];
    logic                      running_out_reg;
    logic                      write_out_reg;

    // Combinational stage values
    logic signed [MIX_W-1:0]   cx, cy, cz;
    logic signed [MIX_W-1:0]   mix_val [NUM_WHEELS];
    logic [LIM_W-1:0]          lim_val;
    logic [MAG_W-1:0]          mag_val [NUM_WHEELS];
    logic [MAG_W-1:0]          norm_val;
    logic [PROD_W-1:0]         trial   [NUM_WHEELS];
    logic                      fits    [NUM_WHEELS];
    logic signed [WHEEL_W-1:0] tgt_val [NUM_WHEELS];
    logic signed [WHEEL_W-1:0] ramp_val [NUM_WHEELS];
    logic                      all_zero, any_applied, any_move;

    assign status.is_drive = (cmd_reg == CMD_DRIVE);

    // Clamp axes, mix and pick the limit
    always_comb
    begin
        cx = clamp_axis(ax_reg);
        cy = clamp_axis(ay_reg);
        cz = clamp_axis(az_reg);
        mix_val[0] = cy + cx - cz;
        mix_val[1] = cy - cx + cz;
        mix_val[2] = cy - cx - cz;
        mix_val[3] = cy + cx + cz;
        if (req_reg < REQ_MIN)
            lim_val = LIM_W'(MIN_LIMIT);
        else if (req_reg > {1'b0, max_speed})
            lim_val = max_speed;
        else
            lim_val = req_reg[LIM_W-1:0];
    end

    // Magnitudes and the normalising divisor
    always_comb
    begin
        norm_val = NORM_MIN;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            mag_val[i] = mix_reg[i][MIX_W-1] ? MAG_W'(-mix_reg[i]) : MAG_W'(mix_reg[i]);
            if (mag_val[i] > norm_val)
                norm_val = mag_val[i];
        end
    end

    // One restoring quotient bit per lane, then clamp and sign the targets
    always_comb
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            logic [QUO_W-1:0]   qc;
            logic [WHEEL_W-1:0] mag8;
            trial[i] = PROD_W'(norm_reg) << cmd.div_shift;
            fits[i]  = (rem_reg[i] >= trial[i]);
            qc = (quo_reg[i] > QUO_CAP) ? QUO_CAP : quo_reg[i];
            mag8 = {1'b0, qc};
            tgt_val[i] = (neg_reg[i] ^ reverse_mask[i]) ? $signed(-mag8) : $signed(mag8);
        end
    end

    // Ramp each applied value toward its target
    always_comb
    begin
        all_zero    = 1'b1;
        any_applied = 1'b0;
        any_move    = 1'b0;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            logic signed [DIFF_W-1:0] d;
            logic signed [DIFF_W-1:0] s;
            d = DIFF_W'(target_reg[i]) - DIFF_W'(applied_reg[i]);
            if (d > STEP_POS)
                s = STEP_POS;
            else if (d < STEP_NEG)
                s = STEP_NEG;
            else
                s = d;
            ramp_val[i] = applied_reg[i] + $signed(s[WHEEL_W-1:0]);
            if (target_reg[i] != '0)
                all_zero = 1'b0;
            if (applied_reg[i] != '0)
                any_applied = 1'b1;
            if (d != '0)
                any_move = 1'b1;
        end
    end

    // Latch the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg <= command;
            ax_reg  <= axis_x;
            ay_reg  <= axis_y;
            az_reg  <= axis_z;
            req_reg <= requested_limit;
        end
    end

    // Mix, normalise and divide
    always_ff @(posedge clk)
    begin
        if (cmd.do_mix)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
                mix_reg[i] <= mix_val[i];
            lim_reg <= lim_val;
        end
        if (cmd.do_norm)
        begin
            norm_reg <= norm_val;
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                rem_reg[i] <= PROD_W'(mag_val[i]) * PROD_W'(lim_reg);
                quo_reg[i] <= '0;
                neg_reg[i] <= mix_reg[i][MIX_W-1];
            end
        end
        if (cmd.div_step)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                if (fits[i])
                begin
                    rem_reg[i] <= rem_reg[i] - trial[i];
                    quo_reg[i][cmd.div_shift] <= 1'b1;
                end
            end
        end
    end

    // Targets, applied values and motor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                target_reg[i]  <= '0;
                applied_reg[i] <= '0;
            end
            motors_reg <= 1'b0;
            write_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.do_tgt)
            begin
                for (int i = 0; i < NUM_WHEELS; i++)
                    target_reg[i] <= tgt_val[i];
            end
            if (cmd.do_exec)
            begin
                case (cmd_reg)
                    CMD_TICK:
                    begin
                        if (all_zero)
                        begin
                            for (int i = 0; i < NUM_WHEELS; i++)
                                applied_reg[i] <= '0;
                            motors_reg <= 1'b0;
                            write_reg  <= motors_reg | any_applied;
                        end
                        else
                        begin
                            for (int i = 0; i < NUM_WHEELS; i++)
                                applied_reg[i] <= ramp_val[i];
                            motors_reg <= 1'b1;
                            write_reg  <= any_move;
                        end
                    end
                    CMD_STOP:
                    begin
                        for (int i = 0; i < NUM_WHEELS; i++)
                        begin
                            target_reg[i]  <= '0;
                            applied_reg[i] <= '0;
                        end
                        motors_reg <= 1'b0;
                        write_reg  <= 1'b1;
                    end
                    default:
                    begin
                        write_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
                wheel_out_reg[i] <= applied_reg[i];
            running_out_reg <= motors_reg;
            write_out_reg   <= write_reg;
        end
    end

    assign wheel_one    = wheel_out_reg[0];
    assign wheel_two    = wheel_out_reg[1];
    assign wheel_three  = wheel_out_reg[2];
    assign wheel_four   = wheel_out_reg[3];
    assign running      = running_out_reg;
    assign write_needed = write_out_reg;

endmodule

`default_nettype wire

@@ src/mecanum_mixer_with_ramp_top.sv @@
`default_nettype none

// Channel  Role    Handshake      Carries
// item     sink    valid/ready    command, axis_x, axis_y, axis_z, requested_limit
// result   source  valid/ready    wheel_one..wheel_four, running, write_needed
// apb      slave   psel/penable   max speed at 0x0, wheel_reverse_mask at 0x4
//
// A drive transaction passes through the exec, mix, norm, div and tgt states before
// done loads the result: the four wheel quotients come from a restoring divider with
// four lanes, one bit per cycle, seven bits each. Tick, stop and the unused code go
// from exec straight to done. The block is back in idle with the load. One transaction
// is in work at a time; the next is accepted while the result waits. A stalled result
// holds in the output register, and a finished transaction waits for it to drain.
// Reset is asynchronous and clears the state, targets, applied values and settings.

module mecanum_mixer_with_ramp_top
    import mmr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    mmr_in_if.sink                  item,
    mmr_out_if.source               result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    logic [LIM_W-1:0]  max_speed_reg;
    logic [MASK_W-1:0] reverse_mask_reg;
    logic              cfg_write;
    dp_cmd_t           dp_cmd;
    dp_status_t        dp_status;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg    <= MAX_SPEED_RESET;
            reverse_mask_reg <= REVERSE_MASK_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == 1'(REG_REVERSE_MASK))
                reverse_mask_reg <= pwdata[MASK_W-1:0];
            else
                max_speed_reg <= pwdata[LIM_W-1:0];
        end
    end

    // Read back
    always_comb
    begin
        if (paddr[2] == 1'(REG_MAX_SPEED))
            prdata = PDATA_W'(max_speed_reg);
        else
            prdata = PDATA_W'(reverse_mask_reg);
    end

    mmr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    mmr_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (dp_cmd),
        .status          (dp_status),
        .command         (item.command),
        .axis_x          (item.axis_x),
        .axis_y          (item.axis_y),
        .axis_z          (item.axis_z),
        .requested_limit (item.requested_limit),
        .max_speed       (max_speed_reg),
        .reverse_mask    (reverse_mask_reg),
        .wheel_one       (result.wheel_one),
        .wheel_two       (result.wheel_two),
        .wheel_three     (result.wheel_three),
        .wheel_four      (result.wheel_four),
        .running         (result.running),
        .write_needed    (result.write_needed)
    );

endmodule

`default_nettype wire

@@ src/mmr_checker.sv @@
`default_nettype none

module mmr_checker
    import mmr_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic signed [WHEEL_W-1:0] w1,
    input wire logic signed [WHEEL_W-1:0] w2,
    input wire logic signed [WHEEL_W-1:0] w3,
    input wire logic signed [WHEEL_W-1:0] w4,
    input wire logic                      running
);

    localparam logic signed [WHEEL_W-1:0] W_MAX = WHEEL_W'(WHEEL_LIMIT);

    // Result valid holds while stalled
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // One transaction in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while busy");

    // Applied wheel values stay in range
    a_wheel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (w1 <= W_MAX) && (w1 >= -W_MAX) && (w2 <= W_MAX) && (w2 >= -W_MAX)
                   && (w3 <= W_MAX) && (w3 >= -W_MAX) && (w4 <= W_MAX) && (w4 >= -W_MAX))
        else $error("wheel value out of range");

    // Stopped motors mean all applied values are zero
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !running |-> (w1 == '0) && (w2 == '0) && (w3 == '0) && (w4 == '0))
        else $error("nonzero wheel with motors off");

endmodule

bind mecanum_mixer_with_ramp_top mmr_checker u_mmr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .w1        (result.wheel_one),
    .w2        (result.wheel_two),
    .w3        (result.wheel_three),
    .w4        (result.wheel_four),
    .running   (result.running)
);

`default_nettype wire
